/* src/ttat_pkg.sv */
// ----------------------------------------------------------------------------
// ttat_pkg
// Shared codes, widths and control types of the time-tagged activity table.
// ----------------------------------------------------------------------------
package ttat_pkg;

    // field widths
    localparam int OP_W     = 3;
    localparam int STATUS_W = 3;
    localparam int SEC_W    = 32;
    localparam int NSEC_W   = 30;

    // parameter defaults
    localparam int DEF_TABLE_DEPTH  = 16;
    localparam int DEF_ACTION_WIDTH = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
    localparam logic [OP_W-1:0] OP_FETCH   = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd2;
    localparam logic [OP_W-1:0] OP_ENABLE  = 3'd3;
    localparam logic [OP_W-1:0] OP_DISABLE = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NONE_DUE    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ALREADY_EN  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ALREADY_DIS = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic load;   // latch the accepted word
        logic exec;   // run a simple op, or start a scan
        logic step;   // examine one slot of the scan
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_scan; // latched op is insert or fetch
        logic hit;     // slot under examination matches
        logic last;    // slot under examination is the last of the sweep
    } sts_t;

endpackage

/* src/ttat_ctrl.sv */
// ----------------------------------------------------------------------------
// ttat_ctrl
// Sequencer: accepts one word, runs it through the datapath, holds the result.
// ----------------------------------------------------------------------------
module ttat_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  ttat_pkg::sts_t sts,
    output ttat_pkg::cmd_t cmd
);
    import ttat_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_RESP
    } state_t;

    state_t state_reg;
    logic   s_ready_reg;
    logic   m_valid_reg;

    // commands decoded from state
    always_comb begin
        cmd.load = s_valid && s_ready_reg;
        cmd.exec = (state_reg == ST_EXEC);
        cmd.step = (state_reg == ST_SCAN);
    end

    // state and handshake outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready_reg) begin
                        state_reg   <= ST_EXEC;
                        s_ready_reg <= 1'b0;
                    end
                end
                ST_EXEC: begin
                    if (sts.is_scan) begin
                        state_reg <= ST_SCAN;
                    end else begin
                        state_reg   <= ST_RESP;
                        m_valid_reg <= 1'b1;
                    end
                end
                ST_SCAN: begin
                    if (sts.hit || sts.last) begin
                        state_reg   <= ST_RESP;
                        m_valid_reg <= 1'b1;
                    end
                end
                ST_RESP: begin
                    if (m_ready) begin
                        state_reg   <= ST_IDLE;
                        m_valid_reg <= 1'b0;
                        s_ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    // only one word in flight: never ready while a result waits
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    // a finished scan always presents its result next
    a_scan_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && (sts.hit || sts.last)) |=> m_valid)
        else $error("scan finished without a result");
`endif

endmodule

/* src/ttat_dpath.sv */
// ----------------------------------------------------------------------------
// ttat_dpath
// Slot table, pointers, enable flag and the one-slot-a-cycle scan unit.
// ----------------------------------------------------------------------------
module ttat_dpath #(
    parameter int TABLE_DEPTH  = ttat_pkg::DEF_TABLE_DEPTH,
    parameter int ACTION_WIDTH = ttat_pkg::DEF_ACTION_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ttat_pkg::cmd_t                cmd,
    output ttat_pkg::sts_t                sts,
    input  logic [ttat_pkg::OP_W-1:0]     s_op,
    input  logic [ttat_pkg::SEC_W-1:0]    s_time_sec,
    input  logic [ttat_pkg::NSEC_W-1:0]   s_time_nsec,
    input  logic [ACTION_WIDTH-1:0]       s_action_in,
    output logic [ttat_pkg::STATUS_W-1:0] m_status,
    output logic [ACTION_WIDTH-1:0]       m_action_out,
    output logic                          m_enabled
);
    import ttat_pkg::*;

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ENTRY_W = SEC_W + NSEC_W + ACTION_WIDTH;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    // latched word
    logic [OP_W-1:0]         op_reg;
    logic [SEC_W-1:0]        sec_reg;
    logic [NSEC_W-1:0]       nsec_reg;
    logic [ACTION_WIDTH-1:0] act_reg;

    // table state
    logic [ENTRY_W-1:0]      mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0]      rdata_reg;
    logic [TABLE_DEPTH-1:0]  valid_reg;
    logic [IDX_W-1:0]        ins_ptr_reg;
    logic [IDX_W-1:0]        fet_ptr_reg;
    logic [IDX_W-1:0]        scan_ptr_reg;
    logic [IDX_W-1:0]        cnt_reg;
    logic                    en_reg;

    // result
    logic [STATUS_W-1:0]     status_reg;
    logic [ACTION_WIDTH-1:0] action_out_reg;

    logic [SEC_W-1:0]        ent_sec;
    logic [NSEC_W-1:0]       ent_nsec;
    logic [ACTION_WIDTH-1:0] ent_act;
    logic                    is_ins;
    logic                    due;
    logic                    hit;
    logic [IDX_W-1:0]        next_ptr;
    logic [IDX_W-1:0]        start_ptr;
    logic [IDX_W-1:0]        rd_addr;

    // entry fields of the slot under examination
    assign ent_sec  = rdata_reg[ENTRY_W-1 -: SEC_W];
    assign ent_nsec = rdata_reg[ACTION_WIDTH +: NSEC_W];
    assign ent_act  = rdata_reg[ACTION_WIDTH-1:0];

    // slot match: free slot for insert, due valid slot for fetch
    assign is_ins = (op_reg == OP_INSERT);
    assign due    = (ent_sec < sec_reg) || ((ent_sec == sec_reg) && (ent_nsec <= nsec_reg));
    assign hit    = is_ins ? !valid_reg[scan_ptr_reg] : (valid_reg[scan_ptr_reg] && due);

    // circular address walk
    assign next_ptr  = (scan_ptr_reg == LAST_IDX) ? '0 : scan_ptr_reg + 1'b1;
    assign start_ptr = (op_reg == OP_FETCH) ? fet_ptr_reg : ins_ptr_reg;
    assign rd_addr   = cmd.exec ? start_ptr : next_ptr;

    assign sts.is_scan = (op_reg == OP_INSERT) || (op_reg == OP_FETCH);
    assign sts.hit     = cmd.step && hit;
    assign sts.last    = cmd.step && (cnt_reg == LAST_IDX);

    // input word latch
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_op;
            sec_reg  <= s_time_sec;
            nsec_reg <= s_time_nsec;
            act_reg  <= s_action_in;
        end
    end

    // entry memory: written on an insert hit, read one slot ahead of the check
    always_ff @(posedge aclk) begin
        if (cmd.step && hit && is_ins) begin
            mem[scan_ptr_reg] <= {sec_reg, nsec_reg, act_reg};
        end
        if (cmd.exec || cmd.step) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // pointers, valid bits, flag and result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            ins_ptr_reg    <= '0;
            fet_ptr_reg    <= '0;
            scan_ptr_reg   <= '0;
            cnt_reg        <= '0;
            en_reg         <= 1'b0;
            status_reg     <= ST_OK;
            action_out_reg <= '0;
        end else begin
            if (cmd.exec) begin
                scan_ptr_reg   <= start_ptr;
                cnt_reg        <= '0;
                status_reg     <= ST_OK;
                action_out_reg <= '0;
                unique case (op_reg)
                    OP_CLEAR: begin
                        valid_reg <= '0;
                        en_reg    <= 1'b0;
                    end
                    OP_ENABLE: begin
                        if (en_reg) begin
                            status_reg <= ST_ALREADY_EN;
                        end else begin
                            en_reg <= 1'b1;
                        end
                    end
                    OP_DISABLE: begin
                        if (!en_reg) begin
                            status_reg <= ST_ALREADY_DIS;
                        end else begin
                            en_reg <= 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.step) begin
                if (hit) begin
                    status_reg <= ST_OK;
                    if (is_ins) begin
                        valid_reg[scan_ptr_reg] <= 1'b1;
                        ins_ptr_reg             <= scan_ptr_reg;
                    end else begin
                        valid_reg[scan_ptr_reg] <= 1'b0;
                        fet_ptr_reg             <= scan_ptr_reg;
                        action_out_reg          <= ent_act;
                    end
                end else if (cnt_reg == LAST_IDX) begin
                    // full sweep, pointer stays put
                    status_reg <= is_ins ? ST_FULL : ST_NONE_DUE;
                end else begin
                    scan_ptr_reg <= next_ptr;
                    cnt_reg      <= cnt_reg + 1'b1;
                end
            end
        end
    end

    assign m_status     = status_reg;
    assign m_action_out = action_out_reg;
    assign m_enabled    = en_reg;

`ifndef SYNTHESIS
    // sweep counter never passes the last slot
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= LAST_IDX)
        else $error("scan counter beyond table depth");

    // a fetched slot is free afterwards
    a_fetch_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && hit && !is_ins) |=> !valid_reg[$past(scan_ptr_reg)])
        else $error("fetched slot still valid");
`endif

endmodule

/* src/time_tagged_activity_table_top.sv */
// ----------------------------------------------------------------------------
// time_tagged_activity_table_top
// Table of time-tagged actions with circular insert and due-fetch scans.
// ----------------------------------------------------------------------------
//   channel | direction | handshake          | word
//   s_      | in        | s_valid / s_ready  | s_op, s_time_sec, s_time_nsec, s_action_in
//   m_      | out       | m_valid / m_ready  | m_status, m_action_out, m_enabled
//
// Insert and fetch examine k slots for one accepted word, k being from 1 to
// TABLE_DEPTH: the entry memory's single read port delivers one slot a cycle.
// Other ops need no scan.
// Reset frees every slot at once; the block is ready in the first cycle after.
// A stalled result holds the block; no new word is taken until it is accepted.
module time_tagged_activity_table_top #(
    parameter int TABLE_DEPTH  = ttat_pkg::DEF_TABLE_DEPTH,
    parameter int ACTION_WIDTH = ttat_pkg::DEF_ACTION_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ttat_pkg::OP_W-1:0]     s_op,
    input  logic [ttat_pkg::SEC_W-1:0]    s_time_sec,
    input  logic [ttat_pkg::NSEC_W-1:0]   s_time_nsec,
    input  logic [ACTION_WIDTH-1:0]       s_action_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ttat_pkg::STATUS_W-1:0] m_status,
    output logic [ACTION_WIDTH-1:0]       m_action_out,
    output logic                          m_enabled
);
    import ttat_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer
    ttat_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // table and scan unit
    ttat_dpath #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .ACTION_WIDTH (ACTION_WIDTH)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_op         (s_op),
        .s_time_sec   (s_time_sec),
        .s_time_nsec  (s_time_nsec),
        .s_action_in  (s_action_in),
        .m_status     (m_status),
        .m_action_out (m_action_out),
        .m_enabled    (m_enabled)
    );

endmodule

/* test/tb_table_pkg.sv */
// ----------------------------------------------------------------------------
// tb_table_pkg
// Scoreboard for the time-tagged activity table testbench: keeps its own copy
// of the slot table, pointers and enable flag, works out the answer to every
// accepted word and compares the block's result words against them in order.
// ----------------------------------------------------------------------------
package tb_table_pkg;

    import ttat_pkg::*;

    localparam int DEPTH = DEF_TABLE_DEPTH;
    localparam int ACT_W = DEF_ACTION_WIDTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam bit [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    // one result word as the block should return it
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [ACT_W-1:0]    action;
        logic                enabled;
    } answer_t;

    class table_tracker;
        bit               slot_used [DEPTH];
        bit [SEC_W-1:0]   due_sec   [DEPTH];
        bit [NSEC_W-1:0]  due_nsec  [DEPTH];
        bit [ACT_W-1:0]   held_act  [DEPTH];
        bit [PTR_W-1:0]   put_ptr;
        bit [PTR_W-1:0]   get_ptr;
        bit               en_flag;
        answer_t          awaited[$];
        int unsigned      errors;

        // print one line per mismatch and count it
        function void report(string what, logic [63:0] got, logic [63:0] want);
            $display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
            errors++;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        // work out the answer to an accepted word and update the table copy
        function void note_word(logic [OP_W-1:0] op, logic [SEC_W-1:0] sec,
                                logic [NSEC_W-1:0] nsec, logic [ACT_W-1:0] act);
            answer_t ans;
            bit      hit;
            ans.status = ST_OK;
            ans.action = '0;
            hit = 1'b0;
            case (op)
                OP_INSERT: begin
                    // first free slot from the insert pointer, pointer stays on it
                    for (int i = 0; i < DEPTH && !hit; i++) begin
                        if (!slot_used[put_ptr]) begin
                            slot_used[put_ptr] = 1'b1;
                            due_sec[put_ptr]   = sec;
                            due_nsec[put_ptr]  = nsec;
                            held_act[put_ptr]  = act;
                            hit = 1'b1;
                        end else begin
                            put_ptr = (put_ptr == LAST_PTR) ? '0 : put_ptr + 1'b1;
                        end
                    end
                    ans.status = hit ? ST_OK : ST_FULL;
                end
                OP_FETCH: begin
                    // first valid slot that is due, seconds then nanoseconds
                    for (int i = 0; i < DEPTH && !hit; i++) begin
                        if (slot_used[get_ptr] && (due_sec[get_ptr] < sec ||
                            (due_sec[get_ptr] == sec && due_nsec[get_ptr] <= nsec))) begin
                            ans.action = held_act[get_ptr];
                            slot_used[get_ptr] = 1'b0;
                            hit = 1'b1;
                        end else begin
                            get_ptr = (get_ptr == LAST_PTR) ? '0 : get_ptr + 1'b1;
                        end
                    end
                    ans.status = hit ? ST_OK : ST_NONE_DUE;
                end
                OP_CLEAR: begin
                    // pointers and contents survive
                    foreach (slot_used[i]) slot_used[i] = 1'b0;
                    en_flag = 1'b0;
                end
                OP_ENABLE: begin
                    if (en_flag) ans.status = ST_ALREADY_EN;
                    en_flag = 1'b1;
                end
                OP_DISABLE: begin
                    if (!en_flag) ans.status = ST_ALREADY_DIS;
                    en_flag = 1'b0;
                end
                default: ;
            endcase
            ans.enabled = en_flag;
            awaited.push_back(ans);
        endfunction

        // compare a result word with the oldest answer awaited
        function void check_result(logic [STATUS_W-1:0] status, logic [ACT_W-1:0] action,
                                   logic enabled);
            answer_t want;
            if (awaited.size() == 0) begin
                report("result word with none awaited, status", 64'(status), 64'd0);
                return;
            end
            want = awaited.pop_front();
            if (status !== want.status)
                report("status", 64'(status), 64'(want.status));
            if (action !== want.action)
                report("action_out", 64'(action), 64'(want.action));
            if (enabled !== want.enabled)
                report("enabled", 64'(enabled), 64'(want.enabled));
        endfunction
    endclass

endpackage

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the time-tagged activity table. A directed opening covers the
// enable/disable errors, a spare op code, a full table, field extremes and due
// comparisons on equal seconds; random insert/fetch bursts then follow under
// four idling phases on the input and result channels, checked word by word.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ttat_pkg::*;
    import tb_table_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
    localparam logic [NSEC_W-1:0] NSEC_TOP     = 30'd999_999_999;
    localparam int ITEMS_PER_PHASE = 236;
    localparam int BURST_LEN       = 24;
    localparam int DRAIN_CYCLES    = 40;
    localparam int CYCLE_LIMIT     = 400_000;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_op = '0;
    logic [SEC_W-1:0]    s_time_sec = '0;
    logic [NSEC_W-1:0]   s_time_nsec = '0;
    logic [ACT_W-1:0]    s_action_in = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [ACT_W-1:0]    m_action_out;
    logic                m_enabled;

    int unsigned  send_idle_pct = 0;
    int unsigned  recv_stall_pct = 0;
    int unsigned  cycle_count = 0;
    table_tracker tracker = new();

    time_tagged_activity_table_top DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_time_sec   (s_time_sec),
        .s_time_nsec  (s_time_nsec),
        .s_action_in  (s_action_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_action_out (m_action_out),
        .m_enabled    (m_enabled)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // result side: check accepted words, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_result(m_status, m_action_out, m_enabled);
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // present one word, hold it until taken, then note it
    task automatic send_word(logic [OP_W-1:0] op, logic [SEC_W-1:0] sec,
                             logic [NSEC_W-1:0] nsec, logic [ACT_W-1:0] act);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid     <= 1'b1;
        s_op        <= op;
        s_time_sec  <= sec;
        s_time_nsec <= nsec;
        s_action_in <= act;
        do @(posedge aclk); while (!s_ready);
        tracker.note_word(op, sec, nsec, act);
    endtask

    // seconds clustered so that equal-seconds comparisons are common
    function automatic logic [SEC_W-1:0] pick_sec();
        case ($urandom_range(6))
            0: return '0;
            1: return 32'd1;
            2: return 32'd2;
            3: return 32'hFFFF_FFFE;
            4: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // nanoseconds near the edges, including values of a billion and above
    function automatic logic [NSEC_W-1:0] pick_nsec();
        case ($urandom_range(6))
            0: return '0;
            1: return NSEC_W'($urandom_range(3));
            2: return NSEC_TOP;
            3: return NSEC_TOP + 1'b1;
            4: return '1;
            default: return NSEC_W'($urandom);
        endcase
    endfunction

    // op mix: fill bursts, drain bursts and mixed bursts
    function automatic logic [OP_W-1:0] pick_op(int unsigned insert_share);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 3) return OP_CLEAR;
        if (r < 7) return OP_ENABLE;
        if (r < 11) return OP_DISABLE;
        if (r < 13) return OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
        if (r < 13 + insert_share) return OP_INSERT;
        return OP_FETCH;
    endfunction

    initial begin
        int unsigned share;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // flag errors and a spare code
        send_word(OP_ENABLE, '0, '0, '0);
        send_word(OP_ENABLE, '1, '1, '1);
        send_word(OP_DISABLE, '0, '0, '0);
        send_word(OP_DISABLE, '0, '0, '0);
        send_word(OP_SPARE_LAST, '1, '1, '1);
        send_word(OP_FETCH, '1, '1, '0);
        // fill the table with extremes, then one more to see it full
        for (int i = 0; i <= DEPTH; i++) begin
            case (i)
                0: send_word(OP_INSERT, '0, '0, '0);
                1: send_word(OP_INSERT, '1, '1, '1);
                2: send_word(OP_INSERT, 32'd1, NSEC_TOP, 32'h5555_5555);
                3: send_word(OP_INSERT, 32'd1, NSEC_TOP + 1'b1, 32'hAAAA_AAAA);
                default: send_word(OP_INSERT, SEC_W'(i + 2),
                                   NSEC_W'($urandom_range(NSEC_TOP)), $urandom);
            endcase
        end
        // due comparisons at the edges
        send_word(OP_FETCH, '0, '0, '0);
        send_word(OP_FETCH, 32'd1, NSEC_TOP, '0);
        send_word(OP_FETCH, '1, '1, '0);
        send_word(OP_CLEAR, '0, '0, '0);
        send_word(OP_FETCH, '1, '1, '0);

        // random bursts under each idling phase
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            share = 44;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % BURST_LEN == 0) begin
                    case ($urandom_range(2))
                        0: share = 70;
                        1: share = 17;
                        default: share = 44;
                    endcase
                end
                send_word(pick_op(share), pick_sec(), pick_nsec(), $urandom);
            end
        end
        s_valid <= 1'b0;

        // drain, then allow for stray words
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.pending() != 0)
            tracker.report("answers left over", 64'(tracker.pending()), 64'd0);
        if (tracker.errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
